### src/sfl_pkg.sv
// Shared types, constants and helper functions of the segregated free-list allocator.
`default_nettype none
package sfl_pkg;

	localparam int AW           = 19;
	localparam int NUM_PAGES    = 64;
	localparam int PAGE_BYTES   = 4096;
	localparam int NUM_CLASSES  = 8;
	localparam int MIN_BLOCK    = 16;
	localparam int MAX_SMALL    = 2048;
	localparam int OFF_W        = 12;
	localparam int SLOT_W       = 8;
	localparam int CLS_W        = 3;
	localparam int PCLS_W       = 4;

	localparam logic [1:0] KIND_ALLOC = 2'd0;
	localparam logic [1:0] KIND_FREE  = 2'd1;
	localparam logic [1:0] KIND_QUERY = 2'd2;

	localparam logic [1:0] STATUS_OK      = 2'd0;
	localparam logic [1:0] STATUS_NO_PAGE = 2'd1;
	localparam logic [1:0] STATUS_IGNORED = 2'd2;

	typedef struct packed {
		logic [1:0]    kind;
		logic [AW-1:0] request_bytes;
		logic [AW-1:0] target_address;
	} req_t;

	typedef struct packed {
		logic [AW-1:0] address;
		logic [AW-1:0] block_size;
		logic [1:0]    status;
	} rsp_t;

	// Smallest power-of-two class that holds the given size, capped at the last class.
	function automatic logic [CLS_W-1:0] class_of(input logic [AW-1:0] bytes);
		logic [CLS_W-1:0] c;
		c = '0;
		for (int i = NUM_CLASSES - 2; i >= 0; i--) begin
			if ((AW'(MIN_BLOCK) << i) >= bytes) begin
				c = CLS_W'(i);
			end
		end
		if ((AW'(MIN_BLOCK) << (NUM_CLASSES - 2)) < bytes) begin
			c = CLS_W'(NUM_CLASSES - 1);
		end
		return c;
	endfunction

endpackage
`default_nettype wire

### src/sfl_ram.sv
// Generic single-write, single-read synchronous RAM with registered read data.
`default_nettype none
module sfl_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 16
) (
	input  wire logic                     clk,
	input  wire logic                     we,
	input  wire logic [$clog2(DEPTH)-1:0] waddr,
	input  wire logic [WIDTH-1:0]         wdata,
	input  wire logic [$clog2(DEPTH)-1:0] raddr,
	output logic      [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata <= mem_q[raddr];
	end

endmodule
`default_nettype wire

### src/segregated_free_list_allocator.sv
// Top level of the segregated size-class free-list allocator.
// The block manages a pool of NUM_PAGES pages of 4096 bytes, numbered from 1.
// Requests arrive on the req channel (req_valid, req_stall, req); one result
// per request leaves on the rsp channel (rsp_valid, rsp_stall, rsp). A
// transfer happens at a clock edge where valid is high and stall is low.
// A request is worked on alone: it is registered in req_q, decoded in
// ST_EXEC, passes through ST_LINK when a free list pop reads memory or
// ST_PAGE when a page lookup reads memory, and its result is moved into
// the output register in ST_DONE before ST_IDLE takes the next request.
// A large allocation of n pages passes through ST_SWEEP, which clears the
// page ownership entries one at a time through the page table's single
// write port. The link memory and page table each have one read and one
// write port, with registered reads. A new request is taken while the previous
// result still waits in the output register. When rsp_stall is held, the
// finished result of the next request waits inside, and req_stall stays high.
// Reset empties all free lists, stops all carving and marks every page free;
// pages above the allocation mark read as unowned, so no clearing pass runs.
`default_nettype none
module segregated_free_list_allocator #(
	parameter int NUM_PAGES = sfl_pkg::NUM_PAGES
) (
	input  wire logic          clk,
	input  wire logic          arst_n,
	input  wire logic          req_valid,
	output logic               req_stall,
	input  wire sfl_pkg::req_t req,
	output logic               rsp_valid,
	input  wire logic          rsp_stall,
	output sfl_pkg::rsp_t      rsp
);

	localparam int AW   = sfl_pkg::AW;
	localparam int PIW  = $clog2(NUM_PAGES);
	localparam int FW   = $clog2(NUM_PAGES + 1);
	localparam int LW   = PIW + sfl_pkg::SLOT_W;
	localparam int LDEP = NUM_PAGES * (sfl_pkg::PAGE_BYTES / sfl_pkg::MIN_BLOCK);
	localparam int CW   = sfl_pkg::CLS_W;
	localparam int OW   = sfl_pkg::OFF_W;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_EXEC,
		ST_LINK,
		ST_PAGE,
		ST_SWEEP,
		ST_DONE
	} state_t;

	state_t        state_q;
	sfl_pkg::req_t req_q;
	sfl_pkg::rsp_t res_q;
	sfl_pkg::rsp_t rsp_q;
	logic          rsp_valid_q;
	logic [AW-1:0] head_q  [sfl_pkg::NUM_CLASSES];
	logic [AW-1:0] carve_q [sfl_pkg::NUM_CLASSES];
	logic [FW-1:0] fresh_q;
	logic [FW-1:0] sweep_q;
	logic [FW-1:0] end_q;
	logic [CW-1:0] cls_q;

	// Link index of a block: page minus one, then the 16-byte slot in the page.
	function automatic logic [LW-1:0] link_idx(input logic [AW-1:0] a);
		logic [PIW-1:0] pm1;
		pm1 = PIW'(32'(a[AW-1:OW]) - 32'd1);
		return {pm1, a[OW-1:4]};
	endfunction

	// Execute-stage decode of the held request.
	logic [CW-1:0]  c_e;
	logic [AW-1:0]  sz_e;
	logic           small_e;
	logic [AW-1:0]  head_e;
	logic [AW-1:0]  carve_e;
	logic [AW-1:0]  carve_nxt_e;
	logic [AW-1:0]  fresh_addr_e;
	logic [AW-1:0]  fresh_nxt_e;
	logic [7:0]     n_e;
	logic           large_fit_e;
	logic [AW-OW-1:0] tpage_e;
	logic           towned_e;

	always_comb begin
		c_e          = sfl_pkg::class_of(req_q.request_bytes);
		sz_e         = AW'(sfl_pkg::MIN_BLOCK) << c_e;
		small_e      = req_q.request_bytes <= AW'(sfl_pkg::MAX_SMALL);
		head_e       = head_q[c_e];
		carve_e      = carve_q[c_e];
		carve_nxt_e  = carve_e + sz_e;
		fresh_addr_e = ((AW'(fresh_q) + AW'(1)) << OW) + sz_e;
		fresh_nxt_e  = fresh_addr_e + sz_e;
		n_e          = 8'((20'(req_q.request_bytes) + 20'd4095) >> OW);
		large_fit_e  = 32'(n_e) <= (32'(NUM_PAGES) - 32'(fresh_q));
		tpage_e      = req_q.target_address[AW-1:OW];
		towned_e     = (tpage_e != '0) && (32'(tpage_e) <= 32'(fresh_q));
	end

	// Page-lookup stage: class of the target page and the aligned block.
	logic [sfl_pkg::PCLS_W-1:0] page_rdata;
	logic           cvalid_p;
	logic [CW-1:0]  cc_p;
	logic [OW-1:0]  csz_p;
	logic [OW-1:0]  blkoff_p;
	logic [AW-1:0]  blk_p;
	logic           header_p;

	always_comb begin
		cvalid_p = (page_rdata != '0) &&
			(32'(page_rdata) <= 32'(sfl_pkg::NUM_CLASSES));
		cc_p     = CW'(page_rdata - 4'd1);
		csz_p    = OW'(sfl_pkg::MIN_BLOCK) << cc_p;
		header_p = req_q.target_address[OW-1:0] < csz_p;
		blkoff_p = req_q.target_address[OW-1:0] & ~(csz_p - OW'(1));
		blk_p    = {req_q.target_address[AW-1:OW], blkoff_p};
	end

	// Memory ports.
	logic                       link_we;
	logic [LW-1:0]              link_waddr;
	logic [AW-1:0]              link_rdata;
	logic                       page_we;
	logic [PIW-1:0]             page_waddr;
	logic [sfl_pkg::PCLS_W-1:0] page_wdata;

	always_comb begin
		link_we    = (state_q == ST_PAGE) && (req_q.kind == sfl_pkg::KIND_FREE) &&
			cvalid_p && !header_p;
		link_waddr = link_idx(blk_p);
		page_we    = 1'b0;
		page_waddr = PIW'(fresh_q);
		page_wdata = sfl_pkg::PCLS_W'(c_e) + 4'd1;
		if (state_q == ST_EXEC && req_q.kind == sfl_pkg::KIND_ALLOC && small_e &&
			head_e == '0 && carve_e == '0 && 32'(fresh_q) < 32'(NUM_PAGES)) begin
			page_we = 1'b1;
		end
		if (state_q == ST_SWEEP) begin
			page_we    = 1'b1;
			page_waddr = PIW'(sweep_q);
			page_wdata = '0;
		end
	end

	sfl_ram #(
		.WIDTH(AW),
		.DEPTH(LDEP)
	) u_link_ram (
		.clk  (clk),
		.we   (link_we),
		.waddr(link_waddr),
		.wdata(head_q[cc_p]),
		.raddr(link_idx(head_e)),
		.rdata(link_rdata)
	);

	sfl_ram #(
		.WIDTH(sfl_pkg::PCLS_W),
		.DEPTH(NUM_PAGES)
	) u_page_ram (
		.clk  (clk),
		.we   (page_we),
		.waddr(page_waddr),
		.wdata(page_wdata),
		.raddr(PIW'(32'(tpage_e) - 32'd1)),
		.rdata(page_rdata)
	);

	assign req_stall = state_q != ST_IDLE;
	assign rsp_valid = rsp_valid_q;
	assign rsp       = rsp_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			rsp_valid_q <= 1'b0;
			fresh_q     <= '0;
			for (int i = 0; i < sfl_pkg::NUM_CLASSES; i++) begin
				head_q[i]  <= '0;
				carve_q[i] <= '0;
			end
		end else begin
			if (rsp_valid_q && !rsp_stall) begin
				rsp_valid_q <= 1'b0;
			end
			case (state_q)
				ST_IDLE: begin
					if (req_valid) begin
						req_q   <= req;
						state_q <= ST_EXEC;
					end
				end
				ST_EXEC: begin
					res_q   <= '{address: '0, block_size: '0, status: sfl_pkg::STATUS_IGNORED};
					state_q <= ST_DONE;
					cls_q   <= c_e;
					case (req_q.kind)
						sfl_pkg::KIND_ALLOC: begin
							if (small_e) begin
								if (head_e != '0) begin
									res_q   <= '{address: head_e, block_size: sz_e,
										status: sfl_pkg::STATUS_OK};
									state_q <= ST_LINK;
								end else if (carve_e != '0) begin
									res_q <= '{address: carve_e, block_size: sz_e,
										status: sfl_pkg::STATUS_OK};
									carve_q[c_e] <= (carve_nxt_e[OW-1:0] == '0) ?
										'0 : carve_nxt_e;
								end else if (32'(fresh_q) < 32'(NUM_PAGES)) begin
									res_q <= '{address: fresh_addr_e, block_size: sz_e,
										status: sfl_pkg::STATUS_OK};
									carve_q[c_e] <= (fresh_nxt_e[OW-1:0] == '0) ?
										'0 : fresh_nxt_e;
									fresh_q <= fresh_q + FW'(1);
								end else begin
									res_q.status <= sfl_pkg::STATUS_NO_PAGE;
								end
							end else if (large_fit_e) begin
								res_q <= '{address: (AW'(fresh_q) + AW'(1)) << OW,
									block_size: AW'(n_e) << OW,
									status: sfl_pkg::STATUS_OK};
								fresh_q <= fresh_q + FW'(n_e);
								sweep_q <= fresh_q;
								end_q   <= fresh_q + FW'(n_e);
								state_q <= ST_SWEEP;
							end else begin
								res_q.status <= sfl_pkg::STATUS_NO_PAGE;
							end
						end
						sfl_pkg::KIND_FREE, sfl_pkg::KIND_QUERY: begin
							if (towned_e) begin
								state_q <= ST_PAGE;
							end
						end
						default: begin
							state_q <= ST_DONE;
						end
					endcase
				end
				ST_LINK: begin
					// Pop: the head's link word becomes the new head.
					head_q[cls_q] <= link_rdata;
					state_q       <= ST_DONE;
				end
				ST_PAGE: begin
					if (cvalid_p) begin
						if (req_q.kind == sfl_pkg::KIND_QUERY) begin
							res_q.block_size <= AW'(sfl_pkg::MIN_BLOCK) << cc_p;
							res_q.status     <= sfl_pkg::STATUS_OK;
						end else if (!header_p) begin
							head_q[cc_p] <= blk_p;
							res_q.status <= sfl_pkg::STATUS_OK;
						end
					end
					state_q <= ST_DONE;
				end
				ST_SWEEP: begin
					sweep_q <= sweep_q + FW'(1);
					if (sweep_q + FW'(1) == end_q) begin
						state_q <= ST_DONE;
					end
				end
				ST_DONE: begin
					if (!rsp_valid_q || !rsp_stall) begin
						rsp_q       <= res_q;
						rsp_valid_q <= 1'b1;
						state_q     <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

endmodule
`default_nettype wire
